// ===== rtl/nprs_pkg.sv =====
// Shared types and constants for the nearest pending request server.
// Used by every module in rtl/; depends on nothing.
package nprs_pkg;

  localparam int NUM_POSITIONS  = 1024;
  localparam int POS_BITS       = $clog2(NUM_POSITIONS);
  localparam int COUNT_BITS     = 16;
  localparam int WORD_BITS      = 32;
  localparam int WORD_IDX_BITS  = $clog2(WORD_BITS);
  localparam int NUM_WORDS      = NUM_POSITIONS / WORD_BITS;
  localparam int WORD_ADDR_BITS = POS_BITS - WORD_IDX_BITS;
  localparam int DIST_BITS      = 32;

  localparam logic [POS_BITS-1:0] TRACK_RESET = POS_BITS'(NUM_POSITIONS - 1);

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_SERVE = 1'b1;

  typedef struct packed {
    logic                action;
    logic [POS_BITS-1:0] position;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [POS_BITS-1:0]  served_position;
    logic [DIST_BITS-1:0] total_distance;
  } rsp_t;

  // one job for the shared bit search unit
  typedef struct packed {
    logic [WORD_BITS-1:0]     vec;
    logic                     up;
    logic [WORD_IDX_BITS-1:0] start;
    logic                     en;
  } srch_req_t;

  typedef struct packed {
    logic                      en;
    logic [WORD_ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0]      data;
  } word_wr_t;

  typedef struct packed {
    logic                  en;
    logic [POS_BITS-1:0]   addr;
    logic [COUNT_BITS-1:0] data;
  } cnt_wr_t;

endpackage

// ===== rtl/nprs_search.sv =====
// Shared bit search unit: nearest set bit at or above / at or below a start index.
// Depends on nprs_pkg.
module nprs_search import nprs_pkg::*; (
  input  srch_req_t                req,
  output logic                     hit,
  output logic [WORD_IDX_BITS-1:0] idx
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;

  always_comb begin
    if (req.up) begin
      mask = {WORD_BITS{1'b1}} << req.start;
    end else begin
      mask = {WORD_BITS{1'b1}} >> (WORD_IDX_BITS'(WORD_BITS - 1) - req.start);
    end
    cand = req.en ? (req.vec & mask) : '0;
  end

  // up: lowest candidate, down: highest candidate
  always_comb begin
    idx = '0;
    if (req.up) begin
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        if (cand[i]) idx = WORD_IDX_BITS'(i);
      end
    end else begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (cand[i]) idx = WORD_IDX_BITS'(i);
      end
    end
  end

  assign hit = |cand;

endmodule

// ===== rtl/nprs_bitmap.sv =====
// Occupancy bitmap: one word memory plus a summary register of non-empty words.
// A word whose summary bit is clear reads as zero, so clearing needs no sweep. Uses nprs_pkg.
module nprs_bitmap import nprs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      rd_en,
  input  logic [WORD_ADDR_BITS-1:0] rd_addr,
  input  word_wr_t                  wr,
  output logic [WORD_BITS-1:0]      rd_word,
  output logic [NUM_WORDS-1:0]      summary
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] mem_q;
  logic                 live_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      live_q <= summary[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      summary <= '0;
    end else if (wr.en) begin
      summary[wr.addr] <= |wr.data;
    end
  end

  assign rd_word = live_q ? mem_q : '0;

endmodule

// ===== rtl/nprs_counts.sv =====
// Per-position request count memory, one read and one write port, registered read.
// Entries are only meaningful where the bitmap bit is set. Uses nprs_pkg.
module nprs_counts import nprs_pkg::*; (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [POS_BITS-1:0]   rd_addr,
  input  cnt_wr_t               wr,
  output logic [COUNT_BITS-1:0] rd_data
);

  logic [COUNT_BITS-1:0] mem [NUM_POSITIONS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nearest_pending_request_server.sv =====
// Add: no result; busy while the count and bitmap word are written. Serve: the result
// is registered after sequential passes of the one bit search unit (head word, and
// if it misses, word summary and found word; each way) and the registered memory reads.
// Next request is taken only once the result has gone. Synchronous rst: head 0,
// direction up, total 0, track_length 1023; counts are invalidated at once via the
// summary register, so there is no clearing sweep.
module nearest_pending_request_server import nprs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [POS_BITS-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  req_t                in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsp_t                out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_WR, S_UP_WORD, S_UP_SUM, S_UP_FINE,
    S_DN_WORD, S_DN_SUM, S_DN_FINE, S_DECIDE, S_UPD_WR
  } state_t;

  state_t                   state;
  req_t                     req;
  logic [POS_BITS-1:0]      track_length;
  logic [POS_BITS-1:0]      head;
  logic                     moving_up;
  logic [DIST_BITS-1:0]     total;
  logic [POS_BITS-1:0]      up_pos, dn_pos, target;
  logic                     has_up, has_dn;
  logic [WORD_ADDR_BITS-1:0] wsel;
  logic [WORD_BITS-1:0]     hword;

  logic                      in_fire;
  logic [WORD_ADDR_BITS-1:0] hw;
  logic [WORD_IDX_BITS-1:0]  hb;
  srch_req_t                 srch;
  logic                      srch_hit;
  logic [WORD_IDX_BITS-1:0]  srch_idx;

  logic                      word_rd_en, cnt_rd_en;
  logic [WORD_ADDR_BITS-1:0] word_rd_addr;
  logic [POS_BITS-1:0]       cnt_rd_addr;
  word_wr_t                  word_wr;
  cnt_wr_t                   cnt_wr;
  logic [WORD_BITS-1:0]      word_q;
  logic [NUM_WORDS-1:0]      summary;
  logic [COUNT_BITS-1:0]     cnt_q;

  logic [POS_BITS-1:0]       dist_up, dist_dn, target_c, seek_len;
  logic [DIST_BITS:0]        sum_wide;
  logic [DIST_BITS-1:0]      total_c;
  logic [WORD_BITS-1:0]      add_bit;
  logic [COUNT_BITS-1:0]     add_cnt;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign in_fire  = in_valid && in_ready;
  assign hw       = head[POS_BITS-1:WORD_IDX_BITS];
  assign hb       = head[WORD_IDX_BITS-1:0];

  nprs_search u_search (
    .req (srch),
    .hit (srch_hit),
    .idx (srch_idx)
  );

  nprs_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .clr     (cfg_wr_en),
    .rd_en   (word_rd_en),
    .rd_addr (word_rd_addr),
    .wr      (word_wr),
    .rd_word (word_q),
    .summary (summary)
  );

  nprs_counts u_counts (
    .clk     (clk),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .wr      (cnt_wr),
    .rd_data (cnt_q)
  );

  // search unit job per step
  always_comb begin
    srch       = '0;
    srch.vec   = word_q;
    srch.up    = 1'b1;
    srch.start = hb;
    srch.en    = 1'b1;
    case (state)
      S_UP_SUM: begin
        srch.vec   = summary;
        srch.start = hw + WORD_ADDR_BITS'(1);
        srch.en    = (hw != '1);
      end
      S_UP_FINE: begin
        srch.start = '0;
      end
      S_DN_WORD: begin
        srch.vec = hword;
        srch.up  = 1'b0;
      end
      S_DN_SUM: begin
        srch.vec   = summary;
        srch.up    = 1'b0;
        srch.start = hw - WORD_ADDR_BITS'(1);
        srch.en    = (hw != '0);
      end
      S_DN_FINE: begin
        srch.up    = 1'b0;
        srch.start = '1;
      end
      default: begin
      end
    endcase
  end

  // nearest candidate, ties to the side of the last move
  always_comb begin
    dist_up = up_pos - head;
    dist_dn = head - dn_pos;
    if (!has_dn) begin
      target_c = up_pos;
    end else if (!has_up) begin
      target_c = dn_pos;
    end else if (moving_up) begin
      target_c = (dist_dn < dist_up) ? dn_pos : up_pos;
    end else begin
      target_c = (dist_up < dist_dn) ? up_pos : dn_pos;
    end
    seek_len = (target_c > head) ? (target_c - head) : (head - target_c);
    sum_wide = {1'b0, total} + (DIST_BITS + 1)'(seek_len);
    total_c  = sum_wide[DIST_BITS] ? '1 : sum_wide[DIST_BITS-1:0];
  end

  always_comb begin
    add_bit = WORD_BITS'(1) << req.position[WORD_IDX_BITS-1:0];
    add_cnt = (|(word_q & add_bit)) ? cnt_q : '0;
  end

  // memory ports
  always_comb begin
    word_rd_en   = 1'b0;
    word_rd_addr = hw;
    cnt_rd_en    = 1'b0;
    cnt_rd_addr  = in_data.position;
    word_wr      = '0;
    cnt_wr       = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          word_rd_en = 1'b1;
          cnt_rd_en  = (in_data.action == ACT_ADD);
          if (in_data.action == ACT_ADD) begin
            word_rd_addr = in_data.position[POS_BITS-1:WORD_IDX_BITS];
          end
        end
      end
      S_ADD_WR: begin
        if (req.position <= track_length && add_cnt != '1) begin
          cnt_wr.en    = 1'b1;
          cnt_wr.addr  = req.position;
          cnt_wr.data  = add_cnt + COUNT_BITS'(1);
          word_wr.en   = 1'b1;
          word_wr.addr = req.position[POS_BITS-1:WORD_IDX_BITS];
          word_wr.data = word_q | add_bit;
        end
      end
      S_UP_SUM, S_DN_SUM: begin
        word_rd_en   = srch_hit;
        word_rd_addr = srch_idx;
      end
      S_DECIDE: begin
        word_rd_en   = has_up || has_dn;
        word_rd_addr = target_c[POS_BITS-1:WORD_IDX_BITS];
        cnt_rd_en    = has_up || has_dn;
        cnt_rd_addr  = target_c;
      end
      S_UPD_WR: begin
        cnt_wr.en   = 1'b1;
        cnt_wr.addr = target;
        cnt_wr.data = cnt_q - COUNT_BITS'(1);
        // last request at this position: drop its bitmap bit
        if (cnt_q == COUNT_BITS'(1)) begin
          word_wr.en   = 1'b1;
          word_wr.addr = target[POS_BITS-1:WORD_IDX_BITS];
          word_wr.data = word_q & ~(WORD_BITS'(1) << target[WORD_IDX_BITS-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      track_length <= TRACK_RESET;
      head         <= '0;
      moving_up    <= 1'b1;
      total        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        track_length <= cfg_wr_data;
        head         <= '0;
        moving_up    <= 1'b1;
        total        <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            req    <= in_data;
            has_up <= 1'b0;
            has_dn <= 1'b0;
            state  <= (in_data.action == ACT_ADD) ? S_ADD_WR : S_UP_WORD;
          end
        end
        S_ADD_WR: begin
          state <= S_IDLE;
        end
        S_UP_WORD: begin
          hword <= word_q;
          if (srch_hit) begin
            has_up <= 1'b1;
            up_pos <= {hw, srch_idx};
            state  <= S_DN_WORD;
          end else begin
            state <= S_UP_SUM;
          end
        end
        S_UP_SUM: begin
          wsel  <= srch_idx;
          state <= srch_hit ? S_UP_FINE : S_DN_WORD;
        end
        S_UP_FINE: begin
          has_up <= 1'b1;
          up_pos <= {wsel, srch_idx};
          state  <= S_DN_WORD;
        end
        S_DN_WORD: begin
          if (srch_hit) begin
            has_dn <= 1'b1;
            dn_pos <= {hw, srch_idx};
            state  <= S_DECIDE;
          end else begin
            state <= S_DN_SUM;
          end
        end
        S_DN_SUM: begin
          wsel  <= srch_idx;
          state <= srch_hit ? S_DN_FINE : S_DECIDE;
        end
        S_DN_FINE: begin
          has_dn <= 1'b1;
          dn_pos <= {wsel, srch_idx};
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          if (has_up || has_dn) begin
            target <= target_c;
            head   <= target_c;
            total  <= total_c;
            if (target_c > head) begin
              moving_up <= 1'b1;
            end else if (target_c < head) begin
              moving_up <= 1'b0;
            end
            state <= S_UPD_WR;
          end else begin
            out_valid                <= 1'b1;
            out_data.found           <= 1'b0;
            out_data.served_position <= head;
            out_data.total_distance  <= total;
            state                    <= S_IDLE;
          end
        end
        S_UPD_WR: begin
          out_valid                <= 1'b1;
          out_data.found           <= 1'b1;
          out_data.served_position <= target;
          out_data.total_distance  <= total;
          state                    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/nprs_checker.sv =====
// Port-level checks for the nearest pending request server, bound to the top level.
// Depends on nprs_pkg and nearest_pending_request_server.
module nprs_checker import nprs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // a request is never taken while a result still waits
  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  // the block is never ready in the cycle after it takes a request
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready straight after a request was taken");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_pending_request_server nprs_checker u_nprs_checker (.*);

// ===== verif/tb_nearest_pending_request_server.sv =====
// Self-checking testbench for nearest_pending_request_server.
// Drives add/serve requests and compares every response with a local scheduler
// model. Depends on rtl/nprs_pkg.sv and rtl/nearest_pending_request_server.sv.
`timescale 1ns / 1ps

module tb_nearest_pending_request_server;
  import nprs_pkg::*;

  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_CAP     = 50;

  logic                clk;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic [POS_BITS-1:0] cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  req_t                in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  rsp_t                out_data;

  nearest_pending_request_server DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // scheduler model state
  logic [COUNT_BITS-1:0] pend [NUM_POSITIONS];
  logic [POS_BITS-1:0]   head_pos;
  logic [POS_BITS-1:0]   track_len;
  logic                  heading_up;
  logic [DIST_BITS-1:0]  travelled;

  req_t req_backlog[$];
  rsp_t predicted_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_trigger  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  function automatic void clear_tracks();
    foreach (pend[i]) pend[i] = '0;
    head_pos   = '0;
    heading_up = 1'b1;
    travelled  = '0;
  endfunction

  function automatic void apply_request(input req_t r);
    int lim, h, up_at, down_at, tgt;
    logic [DIST_BITS-1:0] step_len;
    rsp_t res;
    lim = int'(track_len);
    if (r.action == ACT_ADD) begin
      if (int'(r.position) <= lim && pend[r.position] != '1)
        pend[r.position] = pend[r.position] + 1'b1;
      return;
    end
    h = (int'(head_pos) > lim) ? lim : int'(head_pos);
    up_at   = -1;
    down_at = -1;
    for (int i = h; i <= lim; i++) begin
      if (pend[i] != '0) begin
        up_at = i;
        break;
      end
    end
    for (int i = h; i >= 0; i--) begin
      if (pend[i] != '0) begin
        down_at = i;
        break;
      end
    end
    res.found           = 1'b0;
    res.served_position = head_pos;
    res.total_distance  = travelled;
    if (up_at >= 0 || down_at >= 0) begin
      if (down_at < 0) tgt = up_at;
      else if (up_at < 0) tgt = down_at;
      // equal distance: stay on the side of the last move
      else if (heading_up) tgt = (h - down_at < up_at - h) ? down_at : up_at;
      else tgt = (up_at - h < h - down_at) ? up_at : down_at;
      if (tgt > int'(head_pos)) begin
        step_len   = DIST_BITS'(tgt - int'(head_pos));
        heading_up = 1'b1;
      end else begin
        step_len = DIST_BITS'(int'(head_pos) - tgt);
        if (tgt < int'(head_pos)) heading_up = 1'b0;
      end
      travelled = (travelled > '1 - step_len) ? '1 : travelled + step_len;
      head_pos  = POS_BITS'(tgt);
      pend[tgt] = pend[tgt] - 1'b1;
      res.found           = 1'b1;
      res.served_position = head_pos;
      res.total_distance  = travelled;
    end
    predicted_replies.push_back(res);
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    if (error_count < REPORT_CAP)
      $error("%s: expected %0d, got %0d", field, want, got);
    error_count++;
  endfunction

  // request driver and model update on each accepted request
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      track_len  = TRACK_RESET;
      clear_tracks();
    end else begin
      if (cfg_wr_en) begin
        track_len = cfg_wr_data;
        clear_tracks();
      end
      if (in_valid && in_ready) apply_request(in_data);
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver back-pressure
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          if (error_count < REPORT_CAP)
            $error("response with none outstanding: found %0d pos %0d total %0d",
                   out_data.found, out_data.served_position, out_data.total_distance);
          error_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_data.found !== want.found)
            note_mismatch("found", want.found, out_data.found);
          if (out_data.served_position !== want.served_position)
            note_mismatch("served_position", want.served_position, out_data.served_position);
          if (out_data.total_distance !== want.total_distance)
            note_mismatch("total_distance", want.total_distance, out_data.total_distance);
        end
      end
      if (hold_seen != hold_trigger) begin
        hold_seen <= hold_trigger;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no request or response moved for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(input logic act, input logic [POS_BITS-1:0] pos);
    req_t r;
    r.action   = act;
    r.position = pos;
    req_backlog.push_back(r);
  endtask

  // wait for every response, then cover the busy cycles of a trailing add
  task automatic settle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_track(input logic [POS_BITS-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_mixed_traffic(input int count, input int span);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 52) begin
        // now and then an add at any position, which may lie past the track end
        if ($urandom_range(9) == 0) push_req(ACT_ADD, POS_BITS'($urandom));
        else push_req(ACT_ADD, POS_BITS'($urandom_range(span)));
      end else begin
        push_req(ACT_SERVE, POS_BITS'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 50;

    // directed: empty serve, track ends, zero-distance serve, ties both ways
    push_req(ACT_SERVE, '0);
    push_req(ACT_ADD, 10'd1023);
    push_req(ACT_ADD, 10'd0);
    push_req(ACT_SERVE, '1);
    push_req(ACT_SERVE, '0);
    push_req(ACT_ADD, 10'd500);
    push_req(ACT_SERVE, 10'd341);
    push_req(ACT_ADD, 10'd498);
    push_req(ACT_ADD, 10'd502);
    push_req(ACT_SERVE, 10'd682);
    push_req(ACT_ADD, 10'd496);
    push_req(ACT_ADD, 10'd500);
    push_req(ACT_SERVE, '0);
    push_req(ACT_ADD, 10'd498);
    push_req(ACT_SERVE, '0);
    push_req(ACT_ADD, 10'd496);
    push_req(ACT_ADD, 10'd500);
    push_req(ACT_SERVE, '0);
    push_req(ACT_ADD, 10'd700);
    push_req(ACT_ADD, 10'd700);
    push_req(ACT_SERVE, '0);
    push_req(ACT_SERVE, '0);
    push_req(ACT_SERVE, '0);
    push_req(ACT_SERVE, '0);

    // short track: adds past the end are dropped
    write_track(10'd5);
    push_req(ACT_ADD, 10'd6);
    push_req(ACT_ADD, 10'd1023);
    push_req(ACT_ADD, 10'd5);
    push_req(ACT_SERVE, '0);
    push_req(ACT_SERVE, '0);

    // only position 0 usable
    write_track(10'd0);
    push_req(ACT_ADD, 10'd1);
    push_req(ACT_ADD, 10'd0);
    push_req(ACT_ADD, 10'd0);
    push_req(ACT_ADD, 10'd1023);
    push_req(ACT_SERVE, '0);
    push_req(ACT_SERVE, '0);
    push_req(ACT_SERVE, '0);

    write_track(10'd1023);
    send_idle_pct = 28;
    recv_idle_pct = 50;
    queue_mixed_traffic(300, 1023);
    settle();
    queue_mixed_traffic(300, 1023);

    write_track(POS_BITS'($urandom_range(63, 8)));
    send_idle_pct = 50;
    recv_idle_pct = 28;
    queue_mixed_traffic(600, int'(cfg_wr_data));
    @(negedge clk);
    hold_trigger++;

    write_track(10'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_mixed_traffic(200, 1);

    write_track(POS_BITS'($urandom_range(1023, 1)));
    queue_mixed_traffic(300, int'(cfg_wr_data));

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
